/* src/buffer_slot_pool_with_tagged_cache_defines.svh */
// Assertion helpers for the checker file bsp_checker.
`ifndef BUFFER_SLOT_POOL_WITH_TAGGED_CACHE_DEFINES_SVH
`define BUFFER_SLOT_POOL_WITH_TAGGED_CACHE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define BSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define BSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bsp_pkg.sv */
`default_nettype none

package bsp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [2:0] {
        OP_REQUEST     = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_CREATE      = 3'd2,
        OP_DESTROY     = 3'd3,
        OP_GET         = 3'd4,
        OP_FRAME_RESET = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        KIND_ALLOC,
        KIND_RELEASE,
        KIND_CREATE,
        KIND_DESTROY,
        KIND_GET,
        KIND_FRAME,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  slot_number;
        logic [31:0] cache_tag;
    } req_t;

    typedef struct packed {
        logic [7:0] granted_slot;
        status_t    status;
    } rsp_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  slot;
        logic [31:0] tag;
    } cmd_t;

    // Queue handshake between front and back.
    typedef struct packed {
        logic push;
        logic full;
    } qin_ctl_t;

    typedef struct packed {
        logic pop;
        logic avail;
    } qout_ctl_t;

endpackage

`default_nettype wire

/* src/bsp_front.sv */
`default_nettype none

module bsp_front #(
    parameter int TRANSIENT_SLOTS = 32
) (
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bsp_pkg::req_t  req_data,
    input  wire logic           queue_full,
    output bsp_pkg::qin_ctl_t   qin,
    output bsp_pkg::cmd_t       cmd
);

    localparam logic [7:0] SLOT_LIMIT = 8'(TRANSIENT_SLOTS);

    logic tag_zero;

    assign tag_zero  = (req_data.cache_tag == 32'd0);
    assign req_stall = queue_full;

    always_comb
    begin
        qin.push = req_valid && !queue_full;
        qin.full = queue_full;
    end

    // Range and zero-tag checks happen here so the back sees a clean kind.
    always_comb
    begin
        cmd.slot = req_data.slot_number;
        cmd.tag  = req_data.cache_tag;
        case (req_data.operation)
            bsp_pkg::OP_REQUEST:
                cmd.kind = bsp_pkg::KIND_ALLOC;
            bsp_pkg::OP_RELEASE:
                cmd.kind = (req_data.slot_number >= SLOT_LIMIT) ? bsp_pkg::KIND_BAD
                                                                : bsp_pkg::KIND_RELEASE;
            bsp_pkg::OP_CREATE:
                cmd.kind = tag_zero ? bsp_pkg::KIND_BAD : bsp_pkg::KIND_CREATE;
            bsp_pkg::OP_DESTROY:
                cmd.kind = tag_zero ? bsp_pkg::KIND_BAD : bsp_pkg::KIND_DESTROY;
            bsp_pkg::OP_GET:
                cmd.kind = tag_zero ? bsp_pkg::KIND_BAD : bsp_pkg::KIND_GET;
            bsp_pkg::OP_FRAME_RESET:
                cmd.kind = bsp_pkg::KIND_FRAME;
            default:
                cmd.kind = bsp_pkg::KIND_BAD;
        endcase
    end

endmodule

`default_nettype wire

/* src/bsp_queue.sv */
`default_nettype none

module bsp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bsp_pkg::qin_ctl_t  qin,
    input  wire bsp_pkg::cmd_t      push_cmd,
    input  wire logic               pop,
    output bsp_pkg::qout_ctl_t      qout,
    output logic                    full,
    output bsp_pkg::cmd_t           head_cmd
);

    localparam int CNT_W = $clog2(bsp_pkg::QUEUE_DEPTH + 1);

    bsp_pkg::cmd_t                 entry_reg [bsp_pkg::QUEUE_DEPTH];
    logic [bsp_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bsp_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (count_reg == CNT_W'(bsp_pkg::QUEUE_DEPTH));
    assign do_push  = qin.push && !qin.full;
    assign do_pop   = pop && (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        qout.avail  = (count_reg != '0);
        qout.pop    = do_pop;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* src/bsp_back.sv */
`default_nettype none

module bsp_back #(
    parameter int TRANSIENT_SLOTS = 32,
    parameter int CACHED_SLOTS    = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bsp_pkg::qout_ctl_t  qout,
    input  wire bsp_pkg::cmd_t       head_cmd,
    output logic                     pop,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output bsp_pkg::rsp_t            rsp_data
);

    localparam int TIDX_W = (TRANSIENT_SLOTS > 1) ? $clog2(TRANSIENT_SLOTS) : 1;
    localparam int CIDX_W = (CACHED_SLOTS > 1) ? $clog2(CACHED_SLOTS) : 1;

    logic [TRANSIENT_SLOTS-1:0] t_used_reg, t_used_next;
    logic [CACHED_SLOTS-1:0]    c_used_reg, c_used_next;
    logic [CACHED_SLOTS-1:0]    c_pend_reg, c_pend_next;
    logic [31:0]                tag_mem [CACHED_SLOTS];

    logic                       rsp_valid_reg, rsp_valid_next;
    bsp_pkg::rsp_t              rsp_data_reg, rsp_data_next;

    logic                       t_found, c_found, hit_any, tag_we;
    logic [TIDX_W-1:0]          t_free, rel_idx;
    logic [CIDX_W-1:0]          c_free, hit_idx;
    logic [CACHED_SLOTS-1:0]    hit_vec;
    bsp_pkg::rsp_t              result;

    assign pop     = qout.avail && (!rsp_valid_reg || !rsp_stall);
    assign rel_idx = head_cmd.slot[TIDX_W-1:0];

    // Lowest free transient and cached slots.
    always_comb
    begin
        t_found = 1'b0;
        t_free  = '0;
        for (int i = TRANSIENT_SLOTS - 1; i >= 0; i--)
        begin
            if (!t_used_reg[i])
            begin
                t_found = 1'b1;
                t_free  = TIDX_W'(i);
            end
        end
        c_found = 1'b0;
        c_free  = '0;
        for (int i = CACHED_SLOTS - 1; i >= 0; i--)
        begin
            if (!c_used_reg[i])
            begin
                c_found = 1'b1;
                c_free  = CIDX_W'(i);
            end
        end
    end

    // Tag lookup over used entries; tags are unique so any hit will do.
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < CACHED_SLOTS; i++)
        begin
            hit_vec[i] = c_used_reg[i] && (tag_mem[i] == head_cmd.tag);
        end
        for (int i = CACHED_SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_any = 1'b1;
                hit_idx = CIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        t_used_next         = t_used_reg;
        c_used_next         = c_used_reg;
        c_pend_next         = c_pend_reg;
        tag_we              = 1'b0;
        result.granted_slot = '0;
        result.status       = bsp_pkg::ST_OK;
        case (head_cmd.kind)
            bsp_pkg::KIND_ALLOC:
                if (!t_found)
                begin
                    result.status = bsp_pkg::ST_FULL;
                end
                else
                begin
                    t_used_next[t_free] = 1'b1;
                    result.granted_slot = 8'(t_free);
                end
            bsp_pkg::KIND_RELEASE:
                if (!t_used_reg[rel_idx])
                begin
                    result.status = bsp_pkg::ST_BAD;
                end
                else
                begin
                    t_used_next[rel_idx] = 1'b0;
                end
            bsp_pkg::KIND_CREATE:
                if (hit_any)
                begin
                    result.status = bsp_pkg::ST_BAD;
                end
                else if (!c_found)
                begin
                    result.status = bsp_pkg::ST_FULL;
                end
                else
                begin
                    c_used_next[c_free] = 1'b1;
                    c_pend_next[c_free] = 1'b0;
                    tag_we              = 1'b1;
                    result.granted_slot = 8'(c_free);
                end
            bsp_pkg::KIND_DESTROY,
            bsp_pkg::KIND_GET:
                if (!hit_any)
                begin
                    result.status = bsp_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    if (head_cmd.kind == bsp_pkg::KIND_DESTROY)
                    begin
                        c_pend_next[hit_idx] = 1'b1;
                    end
                    result.granted_slot = 8'(hit_idx);
                end
            bsp_pkg::KIND_FRAME:
            begin
                t_used_next = '0;
                c_used_next = c_used_reg & ~c_pend_reg;
                c_pend_next = '0;
            end
            default:
                result.status = bsp_pkg::ST_BAD;
        endcase
    end

    always_comb
    begin
        if (qout.pop)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = result;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
            rsp_data_next  = rsp_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_used_reg    <= '0;
            c_used_reg    <= '0;
            c_pend_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (qout.pop)
            begin
                t_used_reg <= t_used_next;
                c_used_reg <= c_used_next;
                c_pend_reg <= c_pend_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        if (qout.pop && tag_we)
        begin
            tag_mem[c_free] <= head_cmd.tag;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

/* src/buffer_slot_pool_with_tagged_cache.sv */
// Channel   Signals                          Direction  Carries
// --------  -------------------------------  ---------  ---------------------------------
// request   req_valid, req_stall, req_data   in         operation, slot_number, cache_tag
// response  rsp_valid, rsp_stall, rsp_data   out        granted_slot, status
//
// Flow: an accepted request is queued, then the back executes it and registers the
//   response; while rsp_stall is low it executes one command per cycle (tag compare,
//   lowest-free encode and pool update in a single step), so the sustained rate is one
//   request per cycle.
// Reset: rst_n clears every pool and the queue at once; the tag store needs no clearing.
// Stalls: rsp_stall holds the response register; the two-entry queue then fills and
//   req_stall rises until the back drains it.
`default_nettype none

module buffer_slot_pool_with_tagged_cache #(
    parameter int TRANSIENT_SLOTS = 32,
    parameter int CACHED_SLOTS    = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bsp_pkg::req_t  req_data,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bsp_pkg::rsp_t       rsp_data
);

    bsp_pkg::qin_ctl_t   qin;
    bsp_pkg::qout_ctl_t  qout;
    bsp_pkg::cmd_t       push_cmd;
    bsp_pkg::cmd_t       head_cmd;
    logic                queue_full;
    logic                pop;

    // Front: accept a request and classify it, flagging bad slots and zero tags.
    bsp_front #(
        .TRANSIENT_SLOTS (TRANSIENT_SLOTS)
    ) u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .queue_full (queue_full),
        .qin        (qin),
        .cmd        (push_cmd)
    );

    // Queue: hold up to two classified commands so either side may stall alone.
    bsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .qin      (qin),
        .push_cmd (push_cmd),
        .pop      (pop),
        .qout     (qout),
        .full     (queue_full),
        .head_cmd (head_cmd)
    );

    // Back: execute against the pools and register the response.
    bsp_back #(
        .TRANSIENT_SLOTS (TRANSIENT_SLOTS),
        .CACHED_SLOTS    (CACHED_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qout      (qout),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

/* src/bsp_checker.sv */
`default_nettype none
`include "buffer_slot_pool_with_tagged_cache_defines.svh"

module bsp_checker #(
    parameter int TRANSIENT_SLOTS = 32,
    parameter int CACHED_SLOTS    = 16
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_stall,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire bsp_pkg::rsp_t  rsp_data
);

    localparam int MAX_SLOTS = (TRANSIENT_SLOTS > CACHED_SLOTS) ? TRANSIENT_SLOTS
                                                                : CACHED_SLOTS;
    localparam logic [8:0] SLOT_BOUND = 9'(MAX_SLOTS);

    `BSP_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled response changed")
    `BSP_ASSERT(a_fail_zero, clk, rst_n, rsp_valid && rsp_data.status != bsp_pkg::ST_OK |-> rsp_data.granted_slot == 8'd0, "failed response carries a slot")
    `BSP_ASSERT(a_slot_range, clk, rst_n, rsp_valid && rsp_data.status == bsp_pkg::ST_OK |-> {1'b0, rsp_data.granted_slot} < SLOT_BOUND, "granted slot beyond pool")
    `BSP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !rsp_valid && !req_stall, "outputs active in reset")

endmodule

bind buffer_slot_pool_with_tagged_cache bsp_checker #(
    .TRANSIENT_SLOTS (TRANSIENT_SLOTS),
    .CACHED_SLOTS    (CACHED_SLOTS)
) u_bsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

/* bench/slot_pool_checker.sv */
`default_nettype none

module slot_pool_checker #(
    parameter int TRANSIENT_SLOTS = 32,
    parameter int CACHED_SLOTS    = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire bsp_pkg::req_t req_data,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_stall,
    input  wire bsp_pkg::rsp_t rsp_data,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int NO_SLOT = 255;

    logic [TRANSIENT_SLOTS-1:0] transient_busy;
    logic [CACHED_SLOTS-1:0]    cached_busy;
    logic [CACHED_SLOTS-1:0]    cached_doomed;
    logic [31:0]                cached_tag_store [CACHED_SLOTS];
    bsp_pkg::rsp_t              grants_due [$];
    int                         errs;

    function automatic int slot_holding(input logic [31:0] tag);
        for (int i = 0; i < CACHED_SLOTS; i++)
        begin
            if (cached_busy[i] && cached_tag_store[i] == tag)
                return i;
        end
        return NO_SLOT;
    endfunction

    // Apply one request to the pool copy and return the grant it earns.
    function automatic bsp_pkg::rsp_t grant_for(input bsp_pkg::req_t r);
        bsp_pkg::rsp_t g;
        int            s;
        g.granted_slot = '0;
        g.status       = bsp_pkg::ST_OK;
        s              = NO_SLOT;
        case (r.operation)
            bsp_pkg::OP_REQUEST:
            begin
                for (int i = TRANSIENT_SLOTS - 1; i >= 0; i--)
                begin
                    if (!transient_busy[i])
                        s = i;
                end
                if (s == NO_SLOT)
                    g.status = bsp_pkg::ST_FULL;
                else
                begin
                    transient_busy[s] = 1'b1;
                    g.granted_slot    = 8'(s);
                end
            end
            bsp_pkg::OP_RELEASE:
            begin
                if (r.slot_number >= TRANSIENT_SLOTS || !transient_busy[r.slot_number])
                    g.status = bsp_pkg::ST_BAD;
                else
                    transient_busy[r.slot_number] = 1'b0;
            end
            bsp_pkg::OP_CREATE:
            begin
                if (r.cache_tag == '0 || slot_holding(r.cache_tag) != NO_SLOT)
                    g.status = bsp_pkg::ST_BAD;
                else
                begin
                    for (int i = CACHED_SLOTS - 1; i >= 0; i--)
                    begin
                        if (!cached_busy[i])
                            s = i;
                    end
                    if (s == NO_SLOT)
                        g.status = bsp_pkg::ST_FULL;
                    else
                    begin
                        cached_busy[s]      = 1'b1;
                        cached_doomed[s]    = 1'b0;
                        cached_tag_store[s] = r.cache_tag;
                        g.granted_slot      = 8'(s);
                    end
                end
            end
            bsp_pkg::OP_DESTROY, bsp_pkg::OP_GET:
            begin
                if (r.cache_tag == '0)
                    g.status = bsp_pkg::ST_BAD;
                else
                begin
                    s = slot_holding(r.cache_tag);
                    if (s == NO_SLOT)
                        g.status = bsp_pkg::ST_NOT_FOUND;
                    else
                    begin
                        if (r.operation == bsp_pkg::OP_DESTROY)
                            cached_doomed[s] = 1'b1;
                        g.granted_slot = 8'(s);
                    end
                end
            end
            bsp_pkg::OP_FRAME_RESET:
            begin
                transient_busy = '0;
                cached_busy    = cached_busy & ~cached_doomed;
                cached_doomed  = '0;
            end
            default:
                g.status = bsp_pkg::ST_BAD;
        endcase
        if (g.status != bsp_pkg::ST_OK)
            g.granted_slot = '0;
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bsp_pkg::rsp_t want;
        if (!rst_n)
        begin
            transient_busy = '0;
            cached_busy    = '0;
            cached_doomed  = '0;
            errs           = 0;
            grants_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare first so a grant never matches a request taken on the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (grants_due.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected grant: slot %0d status %0d",
                                 rsp_data.granted_slot, rsp_data.status);
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (rsp_data.granted_slot !== want.granted_slot
                        || rsp_data.status !== want.status)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("grant mismatch: slot %0d/%0d status %0d/%0d (exp/got)",
                                     want.granted_slot, rsp_data.granted_slot,
                                     want.status, rsp_data.status);
                    end
                end
            end
            if (req_valid && !req_stall)
                grants_due.push_back(grant_for(req_data));
            mismatches  <= errs;
            outstanding <= grants_due.size();
        end
    end

endmodule

`default_nettype wire

/* bench/buffer_slot_pool_with_tagged_cache_test.sv */
`default_nettype none

module buffer_slot_pool_with_tagged_cache_test;

    localparam int TRANSIENT_SLOTS = 32;
    localparam int CACHED_SLOTS    = 16;
    localparam int PHASE_REQUESTS  = 170;
    localparam int HOLD_OFF_CYCLES = 300;

    // Operation codes the block must reject as bad requests.
    localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b1;
    logic          req_valid = 1'b0;
    logic          req_stall;
    bsp_pkg::req_t req_data  = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    bsp_pkg::rsp_t rsp_data;

    int mismatches;
    int outstanding;

    // Knobs shared between the request driver and the grant receiver.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int frame_pct      = 2;
    bit hold_off_now   = 1'b0;

    // Small set of tags so creates, destroys and gets keep hitting each other.
    logic [31:0] tag_pool [40];

    buffer_slot_pool_with_tagged_cache #(
        .TRANSIENT_SLOTS(TRANSIENT_SLOTS),
        .CACHED_SLOTS   (CACHED_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data)
    );

    slot_pool_checker #(
        .TRANSIENT_SLOTS(TRANSIENT_SLOTS),
        .CACHED_SLOTS   (CACHED_SLOTS)
    ) watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop reset at time zero so the block sees a falling edge, hold it low,
    // then release it for good.
    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Grant receiver: stall at the current rate; on a hold-off request, keep
    // stalling for a long stretch so the queue fills and req_stall rises.
    always @(posedge clk)
    begin
        if (hold_off_now)
        begin
            hold_off_now = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one request: idle first at the current rate, then hold the payload
    // until the block takes it. Each step sees one update of req_valid only.
    task automatic offer(input logic [2:0] op, input logic [7:0] slot, input logic [31:0] tag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= {op, slot, tag};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Mix of operations: mostly well-formed traffic on known tags, plus zero
    // tags, stray slot numbers and the two spare opcodes.
    function automatic bsp_pkg::req_t random_request();
        bsp_pkg::req_t r;
        int            pick;
        int            tag_pick;
        pick     = $urandom_range(99);
        tag_pick = $urandom_range(99);
        r.slot_number = 8'($urandom);
        if (tag_pick < 70)
            r.cache_tag = tag_pool[$urandom_range(39)];
        else if (tag_pick < 78)
            r.cache_tag = '0;
        else
            r.cache_tag = $urandom;
        if (pick < 28)
            r.operation = bsp_pkg::OP_REQUEST;
        else if (pick < 46)
        begin
            r.operation = bsp_pkg::OP_RELEASE;
            if ($urandom_range(99) < 80)
                r.slot_number = 8'($urandom_range(TRANSIENT_SLOTS - 1));
        end
        else if (pick < 64)
            r.operation = bsp_pkg::OP_CREATE;
        else if (pick < 76)
            r.operation = bsp_pkg::OP_DESTROY;
        else if (pick < 88)
            r.operation = bsp_pkg::OP_GET;
        else if (pick < 88 + frame_pct)
            r.operation = bsp_pkg::OP_FRAME_RESET;
        else if (pick < 98)
            r.operation = bsp_pkg::OP_REQUEST;
        else
            r.operation = $urandom_range(1) ? OP_SPARE_LOW : OP_SPARE_HIGH;
        return r;
    endfunction

    initial
    begin
        bsp_pkg::req_t r;
        for (int i = 0; i < 40; i++)
            tag_pool[i] = $urandom;
        tag_pool[0] = 32'hFFFF_FFFF;
        tag_pool[1] = 32'h0000_0001;
        tag_pool[2] = 32'h8000_0000;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Directed: transient allocate and release, including the rejected cases.
        offer(bsp_pkg::OP_REQUEST, 8'h00, 32'h0000_0000);
        offer(bsp_pkg::OP_REQUEST, 8'hFF, 32'hFFFF_FFFF);
        offer(bsp_pkg::OP_RELEASE, 8'h00, 32'h0000_0000);
        offer(bsp_pkg::OP_RELEASE, 8'h00, 32'h0000_0000);       // slot no longer in use
        offer(bsp_pkg::OP_RELEASE, 8'hFF, 32'hFFFF_FFFF);       // far out of range
        offer(bsp_pkg::OP_RELEASE, 8'(TRANSIENT_SLOTS), 32'h0); // first slot past the pool
        offer(bsp_pkg::OP_REQUEST, 8'h00, 32'h0000_0000);       // lowest free slot is reused

        // Directed: cached create, lookup, deferred free.
        offer(bsp_pkg::OP_CREATE, 8'h00, 32'h0000_0000);        // zero tag
        offer(bsp_pkg::OP_CREATE, 8'h00, 32'hFFFF_FFFF);
        offer(bsp_pkg::OP_CREATE, 8'h00, 32'h0000_0001);
        offer(bsp_pkg::OP_CREATE, 8'h00, 32'hFFFF_FFFF);        // duplicate tag
        offer(bsp_pkg::OP_GET, 8'h00, 32'h0000_0001);
        offer(bsp_pkg::OP_GET, 8'h00, 32'h0000_0000);
        offer(bsp_pkg::OP_GET, 8'h00, 32'h1234_5678);           // unknown tag
        offer(bsp_pkg::OP_DESTROY, 8'h00, 32'h0000_0000);
        offer(bsp_pkg::OP_DESTROY, 8'h00, 32'hDEAD_BEEF);       // unknown tag
        offer(bsp_pkg::OP_DESTROY, 8'h00, 32'h0000_0001);
        offer(bsp_pkg::OP_DESTROY, 8'h00, 32'h0000_0001);       // already pending
        offer(bsp_pkg::OP_GET, 8'h00, 32'h0000_0001);           // pending but still found
        offer(bsp_pkg::OP_CREATE, 8'h00, 32'h0000_0001);        // tag still held while pending
        offer(bsp_pkg::OP_FRAME_RESET, 8'h00, 32'h0000_0000);
        offer(bsp_pkg::OP_GET, 8'h00, 32'h0000_0001);           // freed by the frame reset
        offer(bsp_pkg::OP_CREATE, 8'h00, 32'h8000_0000);        // reuses the freed slot
        offer(OP_SPARE_LOW, 8'h00, 32'h0000_0000);
        offer(OP_SPARE_HIGH, 8'hFF, 32'hFFFF_FFFF);

        // Random phases, one per idling pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                // Pick rare or frequent frame resets at random so pools both fill and drain.
                if (n % 50 == 0)
                    frame_pct = $urandom_range(1) ? 2 : 8;
                // Back-pressure: stall the receiver long while requests keep coming.
                if (phase == 0 && n == 60)
                    hold_off_now = 1'b1;
                r = random_request();
                offer(r.operation, r.slot_number, r.cache_tag);
            end
        end

        // Drop valid, let the checker's count catch up, then drain.
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("buffer_slot_pool_with_tagged_cache verification clean");
        else
            $display("buffer_slot_pool_with_tagged_cache verification failed");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #2_000_000;
        $display("buffer_slot_pool_with_tagged_cache verification failed");
        $finish;
    end

endmodule

`default_nettype wire
